// File: design/ifp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg - shared types and constants for the IMU frame parser
// Frame layout constants, the packet kind encoding, the result word and the
// decode function used by the frame check.
// ----------------------------------------------------------------------------
package ifp_pkg;

	// Frame layout
	localparam int FRAME_LEN = 11;
	localparam int HOLD_LEN  = FRAME_LEN - 1;
	localparam int FILL_W    = $clog2(FRAME_LEN);

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] TYPE_MASK = 8'h50;

	localparam logic [7:0] TYPE_ACCEL  = 8'h51;
	localparam logic [7:0] TYPE_RATE   = 8'h52;
	localparam logic [7:0] TYPE_ANGLE  = 8'h53;
	localparam logic [7:0] TYPE_MAGNET = 8'h54;
	localparam logic [7:0] TYPE_QUAT   = 8'h59;

	// Frame status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [2:0] {
		KIND_ACCEL  = 3'd0,
		KIND_RATE   = 3'd1,
		KIND_ANGLE  = 3'd2,
		KIND_MAGNET = 3'd3,
		KIND_QUAT   = 3'd4,
		KIND_OTHER  = 3'd5
	} packet_kind_t;

	// Ten held bytes, entry 0 is the oldest
	typedef logic [HOLD_LEN-1:0][7:0] byte_win_t;

	// Status of the input stage towards the output register
	typedef struct packed {
		logic valid;  // a byte waits in the input register
		logic full;   // this byte completes an eleven byte window
	} win_stat_t;

	// One result word
	typedef struct packed {
		logic               frame_status;
		logic [7:0]         type_code;
		packet_kind_t       packet_kind;
		logic signed [15:0] word_a;
		logic signed [15:0] word_b;
		logic signed [15:0] word_c;
		logic signed [15:0] word_d;
	} frame_res_t;

	function automatic packet_kind_t kind_of(input logic [7:0] t);
		packet_kind_t k;
		case (t)
			TYPE_ACCEL:  k = KIND_ACCEL;
			TYPE_RATE:   k = KIND_RATE;
			TYPE_ANGLE:  k = KIND_ANGLE;
			TYPE_MAGNET: k = KIND_MAGNET;
			TYPE_QUAT:   k = KIND_QUAT;
			default:     k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

// File: design/ifp_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_rx_if - received byte channel
// Valid/ready channel carrying one serial byte per word.
// ----------------------------------------------------------------------------
interface ifp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/ifp_frame_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_frame_if - frame result channel
// Valid/ready channel carrying one frame verdict and its decoded fields.
// ----------------------------------------------------------------------------
interface ifp_frame_if;
	logic               valid;
	logic               ready;
	logic               frame_status;
	logic [7:0]         type_code;
	logic [2:0]         packet_kind;
	logic signed [15:0] word_a;
	logic signed [15:0] word_b;
	logic signed [15:0] word_c;
	logic signed [15:0] word_d;

	modport source (output valid, output frame_status, output type_code,
		output packet_kind, output word_a, output word_b, output word_c,
		output word_d, input ready);
	modport sink (input valid, input frame_status, input type_code,
		input packet_kind, input word_a, input word_b, input word_c,
		input word_d, output ready);
endinterface

// File: design/ifp_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_window - input register and byte window
// Registers each received byte, then appends it to the ten byte window. A byte
// that completes a window is retired only when the output register can take
// the verdict; on a pass the window empties, on a reject it slides by one.
// ----------------------------------------------------------------------------
module ifp_window (
	input  logic                clk,
	input  logic                arst_n,
	ifp_rx_if.sink              rx,
	input  logic                res_room,
	input  logic                pass,
	output ifp_pkg::win_stat_t  stat,
	output ifp_pkg::byte_win_t  win,
	output logic [7:0]          last_byte
);
	import ifp_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [FILL_W-1:0] fill_q;
	byte_win_t         win_q;
	logic              full;
	logic              fire;

	// A byte completing the window needs room downstream
	assign full = (fill_q == FILL_W'(HOLD_LEN));
	assign fire = valid_s1 && (!full || res_room);

	assign rx.ready  = !valid_s1 || fire;
	assign stat      = '{valid: valid_s1, full: full};
	assign win       = win_q;
	assign last_byte = byte_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Fill count: advance while filling, clear on a pass, hold on a reject
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (fire) begin
			if (!full) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pass) begin
				fill_q <= '0;
			end
		end
	end

	// Window bytes: append while filling, slide and append on a reject
	always_ff @(posedge clk) begin
		if (fire) begin
			if (!full) begin
				for (int i = 0; i < HOLD_LEN; i++) begin
					if (fill_q == FILL_W'(i)) begin
						win_q[i] <= byte_s1;
					end
				end
			end else if (!pass) begin
				for (int i = 0; i < HOLD_LEN - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[HOLD_LEN-1] <= byte_s1;
			end
		end
	end

endmodule

// File: design/ifp_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_check - frame check and decode
// Checks the sync byte, the type bits and the checksum of the ten held bytes
// plus the completing byte, and builds the result word.
// ----------------------------------------------------------------------------
module ifp_check (
	input  ifp_pkg::byte_win_t  win,
	input  logic [7:0]          last_byte,
	output logic                pass,
	output ifp_pkg::frame_res_t res
);
	import ifp_pkg::*;

	logic [4:0][7:0] pair_sum;
	logic [7:0]      sum;

	// Sum bytes zero to nine modulo 256 as a shallow tree
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			pair_sum[i] = win[2*i] + win[2*i+1];
		end
		sum = (pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3]) + pair_sum[4];
	end

	assign pass = (win[0] == SYNC_BYTE) &&
		((win[1] & TYPE_MASK) == TYPE_MASK) &&
		(sum == last_byte);

	// Build the verdict; a reject reports only the type byte
	always_comb begin
		res.type_code = win[1];
		if (pass) begin
			res.frame_status = STATUS_OK;
			res.packet_kind  = kind_of(win[1]);
			res.word_a       = signed'({win[3], win[2]});
			res.word_b       = signed'({win[5], win[4]});
			res.word_c       = signed'({win[7], win[6]});
			res.word_d       = signed'({win[9], win[8]});
		end else begin
			res.frame_status = STATUS_REJECT;
			res.packet_kind  = KIND_OTHER;
			res.word_a       = '0;
			res.word_b       = '0;
			res.word_c       = '0;
			res.word_d       = '0;
		end
	end

endmodule

// File: design/ifp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_out_reg - result register
// Holds one verdict until the sink takes it and reports room to the window.
// ----------------------------------------------------------------------------
module ifp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  ifp_pkg::win_stat_t  stat,
	input  ifp_pkg::frame_res_t res,
	output logic                res_room,
	ifp_frame_if.source         frame
);
	import ifp_pkg::*;

	logic       valid_q;
	frame_res_t res_q;
	logic       load;

	assign res_room = !valid_q || frame.ready;
	assign load     = stat.valid && stat.full && res_room;

	// Valid flag: set on a load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frame.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign frame.valid        = valid_q;
	assign frame.frame_status = res_q.frame_status;
	assign frame.type_code    = res_q.type_code;
	assign frame.packet_kind  = res_q.packet_kind;
	assign frame.word_a       = res_q.word_a;
	assign frame.word_b       = res_q.word_b;
	assign frame.word_c       = res_q.word_c;
	assign frame.word_d       = res_q.word_d;

endmodule

// File: design/imu_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser - byte-serial parser for eleven byte IMU frames
// Takes one serial byte per word on rx and keeps a window of up to eleven
// bytes. Each byte that completes a window yields one word on frame: a pass
// (sync 0x55, type bits 0x50 set, checksum of bytes zero to nine in byte ten)
// reports the type, its kind and four signed little-endian words and empties
// the window; a reject reports status 1 with the type byte and drops the
// oldest byte. A byte is taken every cycle unless rx is stalled: it waits in
// the input register, where the window check runs, and a verdict is then
// loaded into the result register and offered on frame until the sink takes
// it. Only a full result register that the sink does not empty stalls rx.
// ----------------------------------------------------------------------------
module imu_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	ifp_rx_if.sink      rx,
	ifp_frame_if.source frame
);
	import ifp_pkg::*;

	win_stat_t  stat;
	byte_win_t  win;
	logic [7:0] last_byte;
	logic       pass;
	logic       res_room;
	frame_res_t res;

	ifp_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.res_room  (res_room),
		.pass      (pass),
		.stat      (stat),
		.win       (win),
		.last_byte (last_byte)
	);

	ifp_check u_check (
		.win       (win),
		.last_byte (last_byte),
		.pass      (pass),
		.res       (res)
	);

	ifp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.res      (res),
		.res_room (res_room),
		.frame    (frame)
	);

endmodule

// File: dv/tb_imu_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_frame_parser - self-checking bench for the IMU frame parser
// Streams serial bytes into the parser: a short directed part, then random
// streams of good frames, corrupted frames and noise. The random phases vary
// their pattern of sender gaps and receiver stalls, and one phase holds the
// output off for a long stretch. A local window model predicts every verdict,
// and a checker compares each output word field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_imu_frame_parser;
	import ifp_pkg::*;

	// Ways to build a frame
	typedef enum int {
		FRM_GOOD,
		FRM_BAD_SUM,
		FRM_BAD_SYNC,
		FRM_BAD_TYPE
	} frame_flaw_t;

	logic clk;
	logic arst_n;

	ifp_rx_if    rx_ch ();
	ifp_frame_if frame_ch ();

	imu_frame_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.frame  (frame_ch)
	);

	// Window model and pending verdicts
	logic [7:0] model_win [FRAME_LEN];
	int         model_fill;
	frame_res_t pending_verdicts [$];

	int fail_count;
	int bytes_sent;
	int idle_pct;
	int stall_pct;
	int hold_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous upper bound on the whole run
	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Model one accepted byte; queue a verdict once eleven bytes are held
	function automatic void predict_verdict(input logic [7:0] b);
		logic [7:0] sum;
		frame_res_t v;
		int i;
		model_win[model_fill] = b;
		model_fill++;
		if (model_fill < FRAME_LEN)
			return;
		sum = 8'h00;
		for (i = 0; i < HOLD_LEN; i++)
			sum = sum + model_win[i];
		v.type_code = model_win[1];
		if (model_win[0] == SYNC_BYTE && (model_win[1] & TYPE_MASK) == TYPE_MASK &&
				sum == model_win[HOLD_LEN]) begin
			v.frame_status = STATUS_OK;
			case (model_win[1])
				TYPE_ACCEL:  v.packet_kind = KIND_ACCEL;
				TYPE_RATE:   v.packet_kind = KIND_RATE;
				TYPE_ANGLE:  v.packet_kind = KIND_ANGLE;
				TYPE_MAGNET: v.packet_kind = KIND_MAGNET;
				TYPE_QUAT:   v.packet_kind = KIND_QUAT;
				default:     v.packet_kind = KIND_OTHER;
			endcase
			v.word_a = {model_win[3], model_win[2]};
			v.word_b = {model_win[5], model_win[4]};
			v.word_c = {model_win[7], model_win[6]};
			v.word_d = {model_win[9], model_win[8]};
			model_fill = 0;
		end else begin
			v.frame_status = STATUS_REJECT;
			v.packet_kind  = KIND_OTHER;
			v.word_a = '0;
			v.word_b = '0;
			v.word_c = '0;
			v.word_d = '0;
			// drop the oldest byte
			for (i = 0; i < HOLD_LEN; i++)
				model_win[i] = model_win[i+1];
			model_fill = HOLD_LEN;
		end
		pending_verdicts.push_back(v);
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Receiver: stall at random, or hold off while the counter runs down
	initial begin
		frame_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				frame_ch.ready = 1'b0;
				hold_cycles--;
			end else begin
				frame_ch.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Compare each output word with the oldest verdict
	always @(posedge clk) begin
		frame_res_t v;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected word, expected none, got status %b type %h",
					$time, frame_ch.frame_status, frame_ch.type_code);
				fail_count++;
			end else begin
				v = pending_verdicts[0];
				pending_verdicts.delete(0);
				check_field("frame_status", 16'(v.frame_status),
					16'(frame_ch.frame_status));
				check_field("type_code", 16'(v.type_code), 16'(frame_ch.type_code));
				check_field("packet_kind", 16'(v.packet_kind),
					16'(frame_ch.packet_kind));
				check_field("word_a", v.word_a, frame_ch.word_a);
				check_field("word_b", v.word_b, frame_ch.word_b);
				check_field("word_c", v.word_c, frame_ch.word_c);
				check_field("word_d", v.word_d, frame_ch.word_d);
			end
		end
	end

	// Offer one byte, with random gaps, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			rx_ch.valid = 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   = 1'b1;
		rx_ch.rx_byte = b;
		do
			@(posedge clk);
		while (!rx_ch.ready);
		predict_verdict(b);
		bytes_sent++;
	endtask

	// Build and send one eleven byte frame, optionally broken
	task automatic send_frame(input logic [7:0] ptype, input logic [15:0] wa,
			input logic [15:0] wb, input logic [15:0] wc, input logic [15:0] wd,
			input frame_flaw_t flaw);
		logic [7:0] fb [FRAME_LEN];
		logic [7:0] sum;
		int i;
		fb[0] = SYNC_BYTE;
		fb[1] = ptype;
		{fb[3], fb[2]} = wa;
		{fb[5], fb[4]} = wb;
		{fb[7], fb[6]} = wc;
		{fb[9], fb[8]} = wd;
		case (flaw)
			FRM_BAD_SYNC: begin
				do
					fb[0] = 8'($urandom_range(255));
				while (fb[0] == SYNC_BYTE);
			end
			FRM_BAD_TYPE: begin
				do
					fb[1] = 8'($urandom_range(255));
				while ((fb[1] & TYPE_MASK) == TYPE_MASK);
			end
			default: ;
		endcase
		sum = 8'h00;
		for (i = 0; i < HOLD_LEN; i++)
			sum = sum + fb[i];
		fb[HOLD_LEN] = (flaw == FRM_BAD_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
		for (i = 0; i < FRAME_LEN; i++)
			send_byte(fb[i]);
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(9))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Word extremes, a sync slip that is then recovered
	task automatic test_directed_frames();
		idle_pct  = 0;
		stall_pct = 0;
		send_frame(TYPE_ACCEL, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, FRM_GOOD);
		send_byte(8'h00);
		send_frame(TYPE_QUAT, 16'h0001, 16'hfffe, 16'h00ff, 16'hff00, FRM_GOOD);
	endtask

	// Mostly good frames of every kind, with broken frames and noise mixed in
	task automatic test_random_stream(input int n_bytes);
		int stop_at;
		int pick;
		int i;
		logic [7:0] ptype;
		frame_flaw_t flaw;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick >= 90) begin
				for (i = $urandom_range(1, 4); i > 0; i--)
					send_byte(8'($urandom_range(255)));
			end else begin
				case ($urandom_range(6))
					0:       ptype = TYPE_ACCEL;
					1:       ptype = TYPE_RATE;
					2:       ptype = TYPE_ANGLE;
					3:       ptype = TYPE_MAGNET;
					4:       ptype = TYPE_QUAT;
					5:       ptype = 8'($urandom_range(255)) | TYPE_MASK;
					default: ptype = 8'($urandom_range(255));
				endcase
				if (pick < 70)
					flaw = FRM_GOOD;
				else if (pick < 78)
					flaw = FRM_BAD_SUM;
				else if (pick < 84)
					flaw = FRM_BAD_SYNC;
				else
					flaw = FRM_BAD_TYPE;
				send_frame(ptype, rand_word(), rand_word(), rand_word(), rand_word(), flaw);
			end
		end
	endtask

	// Hold the output off while bytes keep coming, so the input stalls
	task automatic test_output_holdoff();
		idle_pct    = 0;
		stall_pct   = 0;
		hold_cycles = 300;
		test_random_stream(90);
	endtask

	// Sequence the run
	initial begin
		arst_n         = 1'b0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = 8'h00;
		model_fill     = 0;
		fail_count     = 0;
		bytes_sent     = 0;
		idle_pct       = 0;
		stall_pct      = 0;
		hold_cycles    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_frames();

		idle_pct  = 0;
		stall_pct = 0;
		test_random_stream(210);

		idle_pct  = 61;
		stall_pct = 0;
		test_random_stream(210);

		idle_pct  = 0;
		stall_pct = 61;
		test_random_stream(210);

		idle_pct  = 33;
		stall_pct = 33;
		test_random_stream(210);

		test_output_holdoff();

		// Drain
		@(negedge clk);
		rx_ch.valid = 1'b0;
		stall_pct   = 0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending_verdicts.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
